// ===== rtl/dedup_buffer_flush_policy_top_macros.svh =====
// assertion macros for the dedup buffer flush policy block
`ifndef DEDUP_BUFFER_FLUSH_POLICY_TOP_MACROS_SVH
`define DEDUP_BUFFER_FLUSH_POLICY_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DBFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define DBFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dbfp_pkg.sv =====
// package with types, codes and constants of the dedup buffer flush policy block
`default_nettype none
package dbfp_pkg;

  localparam int GEN_DEPTH_DEF = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CHECK  = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEDUP_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AGE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ROWS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BYTES    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES    = 3'd6;

  localparam logic [39:0] ROWS_MAX   = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] BYTES_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] BLOCKS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] hash_key;
    logic [23:0] block_rows;
    logic [31:0] block_bytes;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic        kept;
    logic        duplicate;
    logic        flushed;
    logic [39:0] flush_rows;
    logic [47:0] flush_bytes;
    logic [31:0] flush_age;
  } result_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic test;
    logic scan;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/dbfp_ctrl.sv =====
// controller state machine sequencing one item through the datapath
`default_nettype none
module dbfp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire dbfp_pkg::sts_t sts,
  output dbfp_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CALC   = 6'b000010,
    S_TEST   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.test = 1'b1;
        state_next = sts.go_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/dbfp_datapath.sv =====
// datapath: config registers, totals, hash generations, scan and result register
`default_nettype none
module dbfp_datapath #(
  parameter int GEN_DEPTH = dbfp_pkg::GEN_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dbfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dbfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire dbfp_pkg::item_t                   item,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output dbfp_pkg::result_t                      result,
  input  wire dbfp_pkg::cmd_t                    cmd,
  output dbfp_pkg::sts_t                         sts
);

  localparam int IW = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;
  localparam int CW = $clog2(GEN_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  // configuration
  logic [7:0]  dedup_window;
  logic [31:0] min_age, max_age;
  logic [39:0] min_rows, max_rows;
  logic [47:0] min_bytes, max_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      dedup_window <= 8'd128;
      min_age      <= 32'd10;
      max_age      <= 32'd100;
      min_rows     <= 40'd10000;
      max_rows     <= 40'd1000000;
      min_bytes    <= 48'd10000000;
      max_bytes    <= 48'd100000000;
    end else if (cfg_we) begin
      case (cfg_index)
        dbfp_pkg::REG_DEDUP_WINDOW: dedup_window <= cfg_data[7:0];
        dbfp_pkg::REG_MIN_AGE:      min_age      <= cfg_data[31:0];
        dbfp_pkg::REG_MAX_AGE:      max_age      <= cfg_data[31:0];
        dbfp_pkg::REG_MIN_ROWS:     min_rows     <= cfg_data[39:0];
        dbfp_pkg::REG_MAX_ROWS:     max_rows     <= cfg_data[39:0];
        dbfp_pkg::REG_MIN_BYTES:    min_bytes    <= cfg_data[47:0];
        dbfp_pkg::REG_MAX_BYTES:    max_bytes    <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // latched item and working registers
  dbfp_pkg::item_t   it;
  dbfp_pkg::result_t res;
  logic [39:0] buf_rows, psum_rows;
  logic [47:0] buf_bytes, psum_bytes;
  logic [15:0] buf_blocks;
  logic [31:0] first_write, age;

  logic [40:0] rows_sum;
  logic [48:0] bytes_sum;
  logic [16:0] blocks_sum;
  assign rows_sum   = {1'b0, buf_rows} + 41'(it.block_rows);
  assign bytes_sum  = {1'b0, buf_bytes} + 49'(it.block_bytes);
  assign blocks_sum = {1'b0, buf_blocks} + 17'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= item;
    end
    if (cmd.calc) begin
      psum_rows  <= rows_sum[40] ? dbfp_pkg::ROWS_MAX : rows_sum[39:0];
      psum_bytes <= bytes_sum[48] ? dbfp_pkg::BYTES_MAX : bytes_sum[47:0];
      age <= (first_write == 32'd0 || it.now_seconds < first_write) ? 32'd0
             : it.now_seconds - first_write;
    end
  end

  logic pass_p, pass_b, any_blocks, rows_in, flush_go, go_scan;
  assign pass_p = (age > min_age && psum_rows > min_rows && psum_bytes > min_bytes)
                  || age > max_age || psum_rows > max_rows || psum_bytes > max_bytes;
  assign pass_b = (age > min_age && buf_rows > min_rows && buf_bytes > min_bytes)
                  || age > max_age || buf_rows > max_rows || buf_bytes > max_bytes;
  assign any_blocks = buf_blocks != 16'd0;
  assign rows_in = it.block_rows != 24'd0;
  assign go_scan = it.action == dbfp_pkg::ACT_INSERT && rows_in;
  assign flush_go = (it.action == dbfp_pkg::ACT_CHECK && any_blocks && pass_b)
                 || (it.action == dbfp_pkg::ACT_FLUSH && any_blocks && buf_rows != 40'd0)
                 || (go_scan && pass_p && any_blocks && pass_b);

  // hash generations: two banks, cur_sel names the current one
  logic [63:0] bank0 [GEN_DEPTH];
  logic [63:0] bank1 [GEN_DEPTH];
  logic [GEN_DEPTH-1:0] v0, v1, v0_next, v1_next;
  logic cur_sel;
  logic [CW-1:0] count;

  // scan
  logic [CW-1:0] cnt;
  logic [IW-1:0] rd_idx, p_idx, f_idx;
  logic          rd_v, c_hit, p_hit, f_found;
  logic [63:0]   rd0, rd1;
  logic          cv, pv;
  logic [63:0]   cd, pd;

  assign cv = cur_sel ? v1[rd_idx] : v0[rd_idx];
  assign pv = cur_sel ? v0[rd_idx] : v1[rd_idx];
  assign cd = cur_sel ? rd1 : rd0;
  assign pd = cur_sel ? rd0 : rd1;
  assign sts.scan_done = cnt == CW'(GEN_DEPTH) && !rd_v;
  assign sts.go_scan = go_scan;

  always_ff @(posedge clk) begin
    if (cmd.scan && cnt < CW'(GEN_DEPTH)) begin
      rd0 <= bank0[cnt[IW-1:0]];
      rd1 <= bank1[cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.test) begin
      cnt <= '0;
      rd_v <= 1'b0;
      c_hit <= 1'b0;
      p_hit <= 1'b0;
      f_found <= 1'b0;
    end else if (cmd.scan) begin
      if (cnt < CW'(GEN_DEPTH)) begin
        rd_v <= 1'b1;
        rd_idx <= cnt[IW-1:0];
        cnt <= cnt + CW'(1);
      end else begin
        rd_v <= 1'b0;
      end
      if (rd_v) begin
        if (cv && cd == it.hash_key) begin
          c_hit <= 1'b1;
        end
        if (pv && pd == it.hash_key && !p_hit) begin
          p_hit <= 1'b1;
          p_idx <= rd_idx;
        end
        if (!cv && !f_found) begin
          f_found <= 1'b1;
          f_idx <= rd_idx;
        end
      end
    end
  end

  // update decision
  logic [LW-1:0] lim, win_ext, dep_ext;
  logic is_new, rot, fs_ok, do_wr, wsel;
  logic [IW-1:0] fs;
  assign win_ext = LW'(dedup_window[7:1]);
  assign dep_ext = LW'(GEN_DEPTH);
  assign lim = (win_ext > dep_ext) ? dep_ext : win_ext;
  assign is_new = !c_hit && !p_hit;
  assign rot = is_new && LW'(count) >= lim;
  assign fs_ok = rot || f_found;
  assign fs = rot ? '0 : f_idx;
  assign do_wr = (is_new || p_hit) && fs_ok;
  assign wsel = rot ? ~cur_sel : cur_sel;

  always_comb begin
    v0_next = v0;
    v1_next = v1;
    if (cmd.update) begin
      if (rot) begin
        if (wsel) begin
          v1_next = '0;
        end else begin
          v0_next = '0;
        end
      end
      if (p_hit && do_wr) begin
        if (cur_sel) begin
          v0_next[p_idx] = 1'b0;
        end else begin
          v1_next[p_idx] = 1'b0;
        end
      end
      if (do_wr) begin
        if (wsel) begin
          v1_next[fs] = 1'b1;
        end else begin
          v0_next[fs] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && do_wr) begin
      if (wsel) begin
        bank1[fs] <= it.hash_key;
      end else begin
        bank0[fs] <= it.hash_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= '0;
      v1 <= '0;
      cur_sel <= 1'b0;
      count <= '0;
      buf_rows <= '0;
      buf_bytes <= '0;
      buf_blocks <= '0;
      first_write <= '0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
      if (cmd.test) begin
        if (flush_go) begin
          buf_rows <= '0;
          buf_bytes <= '0;
          buf_blocks <= '0;
        end
        if (go_scan && (flush_go || first_write == 32'd0)) begin
          first_write <= it.now_seconds;
        end else if (flush_go) begin
          first_write <= '0;
        end
      end
      if (cmd.update) begin
        if (rot) begin
          cur_sel <= ~cur_sel;
          count <= CW'(1);
        end else if (do_wr) begin
          count <= count + CW'(1);
        end
        if (is_new) begin
          buf_rows <= rows_sum[40] ? dbfp_pkg::ROWS_MAX : rows_sum[39:0];
          buf_bytes <= bytes_sum[48] ? dbfp_pkg::BYTES_MAX : bytes_sum[47:0];
          buf_blocks <= blocks_sum[16] ? dbfp_pkg::BLOCKS_MAX : blocks_sum[15:0];
        end
      end
    end
  end

  // result assembly and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= '0;
    end else if (cmd.test && flush_go) begin
      res.flushed <= 1'b1;
      res.flush_rows <= buf_rows;
      res.flush_bytes <= buf_bytes;
      res.flush_age <= age;
    end else if (cmd.update) begin
      res.kept <= is_new;
      res.duplicate <= !is_new;
    end
    if (cmd.out_load) begin
      result <= res;
    end
  end

  assign sts.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dedup_buffer_flush_policy_top.sv =====
// top level of the dedup buffer flush policy block
//
//  channel   signals                               beat
//  item      item_valid / item_ready / item        one action with its time
//  result    result_valid / result_ready / result  one answer per item
//  config    cfg_we / cfg_index / cfg_data         one register write
//
// an insert with nonzero rows has its result valid after one pass over both hash
// banks, one entry per cycle through the registered memory read port; checks, forced
// flushes and other items skip that pass
// the next item is accepted in the cycle after the result register is loaded
// rst is synchronous and clears totals, valid bits and config to defaults
// a held result does not block the next item from entering, only its result load
`default_nettype none
`include "dedup_buffer_flush_policy_top_macros.svh"
module dedup_buffer_flush_policy_top #(
  parameter int GEN_DEPTH = dbfp_pkg::GEN_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [dbfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dbfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire dbfp_pkg::item_t                  item,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output dbfp_pkg::result_t                     result
);

  dbfp_pkg::cmd_t cmd;
  dbfp_pkg::sts_t sts;

  dbfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dbfp_datapath #(
    .GEN_DEPTH (GEN_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cmd          (cmd),
    .sts          (sts)
  );

  `DBFP_ASSERT_NEXT(a_one_item, clk, rst, item_valid && item_ready, !item_ready)
  `DBFP_ASSERT_SAME(a_kept_dup, clk, rst, result_valid, !(result.kept && result.duplicate))
  `DBFP_ASSERT_SAME(a_noflush_zero, clk, rst, result_valid && !result.flushed, result.flush_rows == 40'd0 && result.flush_age == 32'd0)

endmodule
`default_nettype wire
